// ===== hw/rtl/baud_divisor_search_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the baud divisor search core
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BAUD_DIVISOR_SEARCH_CORE_DEFINES_SVH
`define BAUD_DIVISOR_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define BDS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define BDS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bds_pkg.sv =====
// ----------------------------------------------------------------------------
// Baud divisor search package
// Widths, microcode codes and the control store of the search sequencer.
// ----------------------------------------------------------------------------
package bds_pkg;

	localparam int PRESCALE_MAX = 256;
	localparam int SRC_W        = 27;
	localparam int BAUD_W       = 24;
	localparam int FRAC_W       = 4;
	localparam int THR_W        = 8;
	localparam int P_W          = $clog2(PRESCALE_MAX + 1);
	localparam int DIV_W        = SRC_W + FRAC_W;
	localparam int CNT_W        = $clog2(DIV_W + 1);
	localparam int PC_W         = 4;
	localparam int ADDR_W       = 3;
	localparam int DATA_W       = 32;

	localparam logic [THR_W-1:0] THR_RESET   = THR_W'(5);
	localparam logic [SRC_W-1:0] MIN_INT_DIV = SRC_W'(3);

	// Datapath actions. An action fires only when the step does not jump.
	localparam logic [3:0] A_NONE    = 4'd0;
	localparam logic [3:0] A_LOAD    = 4'd1;
	localparam logic [3:0] A_DIV_SP  = 4'd2;
	localparam logic [3:0] A_ST_D    = 4'd3;
	localparam logic [3:0] A_DIV_DB  = 4'd4;
	localparam logic [3:0] A_ST_V    = 4'd5;
	localparam logic [3:0] A_DIV_DV  = 4'd6;
	localparam logic [3:0] A_ST_RATE = 4'd7;
	localparam logic [3:0] A_ERR     = 4'd8;
	localparam logic [3:0] A_UPD     = 4'd9;
	localparam logic [3:0] A_INC_P   = 4'd10;
	localparam logic [3:0] A_EMIT    = 4'd11;

	// Jump conditions.
	localparam logic [2:0] C_NEVER     = 3'd0;
	localparam logic [2:0] C_ALWAYS    = 3'd1;
	localparam logic [2:0] C_NO_IN     = 3'd2;
	localparam logic [2:0] C_BAUD_ZERO = 3'd3;
	localparam logic [2:0] C_DIV_BUSY  = 3'd4;
	localparam logic [2:0] C_INT_LOW   = 3'd5;
	localparam logic [2:0] C_P_LAST    = 3'd6;
	localparam logic [2:0] C_OUT_FULL  = 3'd7;

	// Program addresses that are jump targets.
	localparam logic [PC_W-1:0] ST_IDLE = PC_W'(0);
	localparam logic [PC_W-1:0] ST_TRY  = PC_W'(1);
	localparam logic [PC_W-1:0] ST_WD   = PC_W'(2);
	localparam logic [PC_W-1:0] ST_WV   = PC_W'(4);
	localparam logic [PC_W-1:0] ST_WR   = PC_W'(6);
	localparam logic [PC_W-1:0] ST_EMIT = PC_W'(11);

	localparam logic [ADDR_W-1:0] REG_ERROR_THRESHOLD = ADDR_W'(0);

	typedef struct packed {
		logic [3:0]      act;
		logic [2:0]      cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		w = '{act: A_NONE, cond: C_ALWAYS, target: ST_IDLE};
		unique case (pc)
			PC_W'(0):  w = '{act: A_LOAD,    cond: C_NO_IN,     target: ST_IDLE};
			PC_W'(1):  w = '{act: A_DIV_SP,  cond: C_BAUD_ZERO, target: ST_EMIT};
			PC_W'(2):  w = '{act: A_ST_D,    cond: C_DIV_BUSY,  target: ST_WD};
			PC_W'(3):  w = '{act: A_DIV_DB,  cond: C_NEVER,     target: ST_IDLE};
			PC_W'(4):  w = '{act: A_ST_V,    cond: C_DIV_BUSY,  target: ST_WV};
			PC_W'(5):  w = '{act: A_DIV_DV,  cond: C_INT_LOW,   target: ST_EMIT};
			PC_W'(6):  w = '{act: A_ST_RATE, cond: C_DIV_BUSY,  target: ST_WR};
			PC_W'(7):  w = '{act: A_ERR,     cond: C_NEVER,     target: ST_IDLE};
			PC_W'(8):  w = '{act: A_UPD,     cond: C_NEVER,     target: ST_IDLE};
			PC_W'(9):  w = '{act: A_INC_P,   cond: C_P_LAST,    target: ST_EMIT};
			PC_W'(10): w = '{act: A_NONE,    cond: C_ALWAYS,    target: ST_TRY};
			PC_W'(11): w = '{act: A_EMIT,    cond: C_OUT_FULL,  target: ST_EMIT};
			PC_W'(12): w = '{act: A_NONE,    cond: C_ALWAYS,    target: ST_IDLE};
			default:   w = '{act: A_NONE,    cond: C_ALWAYS,    target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/baud_divisor_search_core.sv =====
// ----------------------------------------------------------------------------
// Baud divisor search core
// Searches clock prescalers for the best fractional UART baud divisor.
// ----------------------------------------------------------------------------
// Usage: an input transfer carries source_clock_hz and bit_rate on the
// in_valid / in_stall channel. The core takes a transfer only while its
// sequencer sits at its idle step; in_stall is high for the whole search.
// Each input gives exactly one result transfer (prescale, int_divider,
// frac_divider, found) on the out_valid / out_stall channel.
// The search time is set by the shared one-bit-per-cycle restoring
// divider, which runs three 31-step divisions per prescaler under the
// microcode program, for at most 256 prescalers.
// The result sits in an output register, so the next input is taken while
// a result still waits; a search that finishes while the receiver stalls
// holds at its emit step until the earlier result has been taken.
// Reset clears the sequencer and the output valid and sets error_threshold
// to 5. error_threshold is written over the APB port at address 0.
// ----------------------------------------------------------------------------
`include "baud_divisor_search_core_defines.svh"

module baud_divisor_search_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [bds_pkg::SRC_W-1:0]  source_clock_hz,
	input  logic [bds_pkg::BAUD_W-1:0] bit_rate,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bds_pkg::P_W-1:0]    prescale,
	output logic [bds_pkg::SRC_W-1:0]  int_divider,
	output logic [bds_pkg::FRAC_W-1:0] frac_divider,
	output logic                       found,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bds_pkg::ADDR_W-1:0] paddr,
	input  logic [bds_pkg::DATA_W-1:0] pwdata,
	output logic [bds_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import bds_pkg::*;

	logic [THR_W-1:0]  thr_q;
	logic [PC_W-1:0]   pc_q;
	ctrl_word_t        cw;
	logic              take;
	logic              fire;

	logic [SRC_W-1:0]  src_q;
	logic [BAUD_W-1:0] baud_q;
	logic [P_W-1:0]    p_q;
	logic [SRC_W-1:0]  d_q;
	logic [DIV_W-1:0]  v_q;
	logic [DIV_W-1:0]  rate_q;
	logic [DIV_W-1:0]  err_q;

	logic              have_q;
	logic [P_W-1:0]    best_p_q;
	logic [SRC_W-1:0]  best_int_q;
	logic [FRAC_W-1:0] best_frac_q;
	logic [DIV_W-1:0]  lowest_err_q;

	logic              out_valid_q;
	logic [P_W-1:0]    prescale_q;
	logic [SRC_W-1:0]  int_div_q;
	logic [FRAC_W-1:0] frac_div_q;
	logic              found_q;

	logic [CNT_W-1:0]  div_cnt_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic              div_busy;
	logic              div_start;
	logic [DIV_W-1:0]  div_a;
	logic [DIV_W-1:0]  div_b;
	logic [DIV_W:0]    div_sh;
	logic [DIV_W:0]    div_diff;

	logic [DIV_W-1:0]  baud_ext;
	logic [DIV_W-1:0]  err_next;
	logic              better;
	logic              cfg_wr;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite &&
		(paddr[ADDR_W-1:2] == REG_ERROR_THRESHOLD[ADDR_W-3:0]);
	assign prdata = (paddr[ADDR_W-1:2] == REG_ERROR_THRESHOLD[ADDR_W-3:0]) ?
		{{(DATA_W-THR_W){1'b0}}, thr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// Sequencer: fetch, evaluate the jump condition, step or jump.
	assign cw       = rom_word(pc_q);
	assign div_busy = (div_cnt_q != '0);

	always_comb begin
		unique case (cw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_IN:     take = !in_valid;
			C_BAUD_ZERO: take = (baud_q == '0);
			C_DIV_BUSY:  take = div_busy;
			C_INT_LOW:   take = (v_q[DIV_W-1:FRAC_W] < MIN_INT_DIV);
			C_P_LAST:    take = (p_q == P_W'(PRESCALE_MAX));
			C_OUT_FULL:  take = out_valid_q && out_stall;
			default:     take = 1'b1;
		endcase
	end

	assign fire     = !take;
	assign in_stall = (pc_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (take) begin
			pc_q <= cw.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

	// Shared restoring divider, one quotient bit per cycle.
	assign div_start = fire && (cw.act == A_DIV_SP || cw.act == A_DIV_DB || cw.act == A_DIV_DV);

	always_comb begin
		unique case (cw.act)
			A_DIV_SP: begin
				div_a = {{(DIV_W-SRC_W){1'b0}}, src_q};
				div_b = {{(DIV_W-P_W){1'b0}}, p_q};
			end
			A_DIV_DB: begin
				div_a = {d_q, {FRAC_W{1'b0}}};
				div_b = {{(DIV_W-BAUD_W){1'b0}}, baud_q};
			end
			default: begin
				div_a = {d_q, {FRAC_W{1'b0}}};
				div_b = v_q;
			end
		endcase
	end

	assign div_sh   = {rem_q, quo_q[DIV_W-1]};
	assign div_diff = div_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_start) begin
			div_cnt_q <= CNT_W'(DIV_W);
		end else if (div_busy) begin
			div_cnt_q <= div_cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			quo_q <= div_a;
			dvs_q <= div_b;
			rem_q <= '0;
		end else if (div_busy) begin
			// The partial remainder stays below the divisor, so it fits DIV_W bits.
			if (!div_diff[DIV_W]) begin
				rem_q <= div_diff[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= div_sh[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	// Search datapath.
	assign baud_ext = {{(DIV_W-BAUD_W){1'b0}}, baud_q};
	assign err_next = (baud_ext > rate_q) ? (baud_ext - rate_q) : (rate_q - baud_ext);
	assign better   = !have_q || (err_q < lowest_err_q) ||
		(err_q < {{(DIV_W-THR_W){1'b0}}, thr_q});

	always_ff @(posedge clk) begin
		if (fire) begin
			unique case (cw.act)
				A_LOAD: begin
					src_q  <= source_clock_hz;
					baud_q <= bit_rate;
					p_q    <= P_W'(1);
				end
				A_ST_D:    d_q    <= quo_q[SRC_W-1:0];
				A_ST_V:    v_q    <= quo_q;
				A_ST_RATE: rate_q <= quo_q;
				A_ERR:     err_q  <= err_next;
				A_INC_P:   p_q    <= p_q + P_W'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (fire && cw.act == A_LOAD) begin
			have_q <= 1'b0;
		end else if (fire && cw.act == A_UPD) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && cw.act == A_LOAD) begin
			best_p_q     <= '0;
			best_int_q   <= '0;
			best_frac_q  <= '0;
			lowest_err_q <= '0;
		end else if (fire && cw.act == A_UPD && better) begin
			best_p_q     <= p_q;
			best_int_q   <= v_q[DIV_W-1:FRAC_W];
			best_frac_q  <= v_q[FRAC_W-1:0];
			lowest_err_q <= err_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && cw.act == A_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && cw.act == A_EMIT) begin
			prescale_q <= best_p_q;
			int_div_q  <= best_int_q;
			frac_div_q <= best_frac_q;
			found_q    <= have_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign prescale     = prescale_q;
	assign int_divider  = int_div_q;
	assign frac_divider = frac_div_q;
	assign found        = found_q;

	// A new result appears only from the emit step.
	`BDS_ASSERT_IMP(a_emit_src, $rose(out_valid_q), $past(pc_q) == ST_EMIT, "result without emit step")
	// The divider is never restarted while it is still running.
	`BDS_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider restarted while busy")
	// A found result always names a prescaler and a divisor of at least three.
	`BDS_ASSERT_NXT(a_found_ok, fire && cw.act == A_EMIT,
		(found_q == (prescale_q != '0)) && (!found_q || int_div_q >= MIN_INT_DIV),
		"inconsistent found result")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the baud divisor search core
// Sends clock and baud rate pairs, predicts the chosen prescaler and
// fractional divisor for each one, and checks every result transfer in
// order. The error threshold register is written over the APB port
// between phases, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int SRC_W  = bds_pkg::SRC_W;
	localparam int BAUD_W = bds_pkg::BAUD_W;
	localparam int P_W    = bds_pkg::P_W;
	localparam int FRAC_W = bds_pkg::FRAC_W;
	localparam int THR_W  = bds_pkg::THR_W;

	localparam logic [bds_pkg::ADDR_W-1:0] THRESHOLD_ADDR =
		bds_pkg::ADDR_W'(4 * bds_pkg::REG_ERROR_THRESHOLD);
	// Byte address of a register index that the block does not have.
	localparam logic [bds_pkg::ADDR_W-1:0] UNMAPPED_ADDR = bds_pkg::ADDR_W'(4);

	localparam longint unsigned SRC_MASK = (64'd1 << SRC_W) - 1;

	typedef struct packed {
		logic [P_W-1:0]    prescale;
		logic [SRC_W-1:0]  int_divider;
		logic [FRAC_W-1:0] frac_divider;
		logic              found;
	} baud_setting_t;

	class divisor_scoreboard;
		baud_setting_t   pending_settings[$];
		logic [THR_W-1:0] err_limit;
		int unsigned     fail_count;
		int unsigned     requests;
		int unsigned     checked;
		int unsigned     found_count;
		int unsigned     full_sweeps;

		function new();
			err_limit   = bds_pkg::THR_RESET;
			fail_count  = 0;
			requests    = 0;
			checked     = 0;
			found_count = 0;
			full_sweeps = 0;
		endfunction

		function int pending();
			return pending_settings.size();
		endfunction

		// Works out the divisor that the search settles on for one request.
		function void note_request(logic [SRC_W-1:0] src_hz, logic [BAUD_W-1:0] baud);
			longint unsigned clk_in, bps, div_clk, fixed_div, int_part, rate, err, lowest_err;
			baud_setting_t   pick;
			bit              have;
			int              p;
			clk_in     = src_hz;
			bps        = baud;
			pick       = '0;
			have       = 0;
			lowest_err = 0;
			if (bps != 0) begin
				for (p = 1; p <= bds_pkg::PRESCALE_MAX; p++) begin
					div_clk   = clk_in / p;
					fixed_div = (div_clk << 4) / bps;
					int_part  = fixed_div >> 4;
					if (int_part < bds_pkg::MIN_INT_DIV) break;
					rate = (div_clk << 4) / fixed_div;
					err  = (bps > rate) ? bps - rate : rate - bps;
					if (!have || err < lowest_err || err < err_limit) begin
						pick.prescale     = p[P_W-1:0];
						pick.int_divider  = int_part[SRC_W-1:0];
						pick.frac_divider = fixed_div[FRAC_W-1:0];
						pick.found        = 1'b1;
						lowest_err        = err;
						have              = 1;
					end
					if (p == bds_pkg::PRESCALE_MAX) full_sweeps++;
				end
			end
			pending_settings.push_back(pick);
			requests++;
		endfunction

		function void check_result(baud_setting_t got);
			baud_setting_t want;
			if (pending_settings.size() == 0) begin
				$display({"%0t: result transfer with nothing outstanding: ",
					"prescale %0d int %0d frac %0d found %0b"},
					$time, got.prescale, got.int_divider, got.frac_divider, got.found);
				fail_count++;
				return;
			end
			want = pending_settings.pop_front();
			checked++;
			if (want.found) found_count++;
			if (got.prescale !== want.prescale) begin
				$display("%0t: prescale expected %0d, got %0d", $time, want.prescale, got.prescale);
				fail_count++;
			end
			if (got.int_divider !== want.int_divider) begin
				$display("%0t: int_divider expected %0d, got %0d",
					$time, want.int_divider, got.int_divider);
				fail_count++;
			end
			if (got.frac_divider !== want.frac_divider) begin
				$display("%0t: frac_divider expected %0d, got %0d",
					$time, want.frac_divider, got.frac_divider);
				fail_count++;
			end
			if (got.found !== want.found) begin
				$display("%0t: found expected %0b, got %0b", $time, want.found, got.found);
				fail_count++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [SRC_W-1:0]              source_clock_hz;
	logic [BAUD_W-1:0]             bit_rate;
	logic                          out_valid;
	logic                          out_stall;
	logic [P_W-1:0]                prescale;
	logic [SRC_W-1:0]              int_divider;
	logic [FRAC_W-1:0]             frac_divider;
	logic                          found;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [bds_pkg::ADDR_W-1:0]    paddr;
	logic [bds_pkg::DATA_W-1:0]    pwdata;
	logic [bds_pkg::DATA_W-1:0]    prdata;
	logic                          pready;

	divisor_scoreboard sb;
	int  hold_cycles;
	bit  calm;
	int  settings_used;

	baud_divisor_search_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.source_clock_hz (source_clock_hz),
		.bit_rate        (bit_rate),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.prescale        (prescale),
		.int_divider     (int_divider),
		.frac_divider    (frac_divider),
		.found           (found),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always #5 clk = ~clk;

	// The result check runs before the new request is noted, so a stray
	// result can never consume the prediction of the same cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result('{prescale: prescale, int_divider: int_divider,
					frac_divider: frac_divider, found: found});
			if (in_valid && !in_stall)
				sb.note_request(source_clock_hz, bit_rate);
		end
	end

	// Receiver side: random stall pattern, plus long hold-offs on request.
	initial begin
		int n;
		int r;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				out_stall <= 1'b1;
			end else if (calm) begin
				n = 1;
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					n = $urandom_range(1, 20);
					out_stall <= 1'b0;
				end else if (r < 90) begin
					n = $urandom_range(1, 4);
					out_stall <= 1'b1;
				end else begin
					n = $urandom_range(20, 300);
					out_stall <= 1'b1;
				end
			end
			repeat (n) @(negedge clk);
		end
	end

	initial begin
		#200_000_000;
		$display("simulation failed");
		$finish;
	end

	// Mostly short searches: the prescaler sweep ends after src / (3 * baud)
	// steps, so the clock is kept within a small multiple of the baud rate.
	function automatic void pick_pair(input bit short_only, output logic [SRC_W-1:0] src,
			output logic [BAUD_W-1:0] baud);
		int unsigned     r;
		int unsigned     bits;
		longint unsigned b;
		longint unsigned s;
		longint unsigned std_baud[8] = '{9600, 19200, 38400, 57600, 115200, 230400,
			460800, 921600};
		longint unsigned std_clk[7] = '{1843200, 8000000, 16000000, 24000000,
			40000000, 48000000, 80000000};
		r = short_only ? 0 : $urandom_range(0, 99);
		if (r < 60) begin
			bits = $urandom_range(1, BAUD_W);
			b = $urandom & ((64'd1 << bits) - 1);
			if (b == 0) b = 1;
			s = b * $urandom_range(2, 45) + $urandom_range(0, 32'(b));
			if (s > SRC_MASK) s = $urandom & SRC_MASK;
		end else if (r < 75) begin
			b = $urandom;
			s = $urandom;
		end else if (r < 85) begin
			b = $urandom_range(0, 40);
			s = $urandom_range(0, 150);
		end else if (r < 90) begin
			b = std_baud[$urandom_range(0, 7)];
			s = std_clk[$urandom_range(0, 6)];
		end else begin
			// Land on or just below the point where the integer part reaches 3.
			b = $urandom & ((64'd1 << BAUD_W) - 1);
			if (b == 0) b = 1;
			s = 3 * b * $urandom_range(1, 8);
			s = s - $urandom_range(0, 1);
			if (s > SRC_MASK) s = $urandom & SRC_MASK;
		end
		src  = s[SRC_W-1:0];
		baud = b[BAUD_W-1:0];
	endfunction

	task automatic send_request(input logic [SRC_W-1:0] src, input logic [BAUD_W-1:0] baud);
		in_valid        <= 1'b1;
		source_clock_hz <= src;
		bit_rate        <= baud;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		@(negedge clk);
	endtask

	task automatic pause_sender();
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (calm || r < 60) gap = 0;
		else if (r < 90) gap = $urandom_range(1, 3);
		else gap = $urandom_range(20, 150);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_all_settled();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(input int count);
		logic [SRC_W-1:0]  src;
		logic [BAUD_W-1:0] baud;
		repeat (count) begin
			pick_pair(1'b0, src, baud);
			send_request(src, baud);
			pause_sender();
		end
	endtask

	task automatic apb_write(input logic [bds_pkg::ADDR_W-1:0] addr,
			input logic [bds_pkg::DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready) break;
		end
		if (addr == THRESHOLD_ADDR) sb.err_limit = data[THR_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_threshold_readback();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= THRESHOLD_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready) break;
		end
		if (prdata !== bds_pkg::DATA_W'(sb.err_limit)) begin
			$display("%0t: error_threshold readback expected %0d, got %0d",
				$time, sb.err_limit, prdata);
			sb.fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Waits until nothing is outstanding; every request yields a result,
	// so a short pause is enough for the sequencer to settle at idle.
	task automatic set_threshold(input logic [bds_pkg::ADDR_W-1:0] addr,
			input logic [bds_pkg::DATA_W-1:0] data);
		wait_all_settled();
		repeat (10) @(negedge clk);
		apb_write(addr, data);
		check_threshold_readback();
		settings_used++;
	endtask

	// Receiver holds off while the sender keeps offering short searches,
	// so the output register fills and the input side backs up.
	task automatic overflow_burst();
		logic [SRC_W-1:0]  src;
		logic [BAUD_W-1:0] baud;
		hold_cycles = 6000;
		repeat (6) begin
			pick_pair(1'b1, src, baud);
			send_request(src, baud);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		sb              = new();
		clk             = 1'b0;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		source_clock_hz = '0;
		bit_rate        = '0;
		out_stall       = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		hold_cycles     = 0;
		calm            = 1'b0;
		settings_used   = 1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		check_threshold_readback();

		// Directed requests at the reset threshold.
		send_request(27'h7FFFFFF, 24'd1);
		send_request(27'd0, 24'd9600);
		send_request(27'd12345, 24'd0);
		send_request(27'd0, 24'd0);
		send_request(27'h7FFFFFF, 24'hFFFFFF);
		send_request(27'd1, 24'd1);
		send_request(27'd3, 24'd1);
		send_request(27'd47, 24'd16);
		send_request(27'd48, 24'd16);
		send_request(27'd768000, 24'd1000);
		send_request(27'd767999, 24'd1000);
		pause_sender();
		send_request(27'd48000000, 24'd115200);
		send_request(27'd48000000, 24'd9600);
		send_request(27'd80000000, 24'd10000000);
		send_request(27'h7FFFFFF, 24'd10000000);
		send_request(27'd1843200, 24'd115200);
		send_request(27'd100000000, 24'd3000000);
		send_request(27'h5555555, 24'hAAAAAA);
		send_request(27'h2AAAAAA, 24'h555555);
		send_request(27'h4000000, 24'h800000);
		run_random(15);

		set_threshold(THRESHOLD_ADDR, 32'd0);
		run_random(8);
		overflow_burst();
		run_random(6);

		set_threshold(THRESHOLD_ADDR, 32'd255);
		send_request(27'd1843200, 24'd115200);
		send_request(27'd16000000, 24'd9600);
		send_request(27'd24000000, 24'd57600);
		run_random(12);

		// A write to an unmapped address must leave the threshold alone.
		set_threshold(UNMAPPED_ADDR, 32'h33);
		calm = 1'b1;
		run_random(12);
		calm = 1'b0;

		set_threshold(THRESHOLD_ADDR,
			{16'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(1, 254))});
		run_random(12);
		wait_all_settled();
		run_random(13);

		wait_all_settled();
		repeat (200) @(posedge clk);
		$display("Checked %0d of %0d searches under %0d threshold settings.",
			sb.checked, sb.requests, settings_used);
		$display("%0d found a divisor and %0d swept every prescaler.",
			sb.found_count, sb.full_sweeps);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bds_pkg.sv
hw/rtl/baud_divisor_search_core.sv
tb/tb_top.sv
